@@ src/scfe_pkg.sv @@
package scfe_pkg;

	// Register indexes on the configuration port.
	localparam logic CFG_DELIM = 1'b0;
	localparam logic CFG_MASK  = 1'b1;

	localparam logic [7:0] DELIM_RESET = 8'h7E;
	localparam logic [7:0] MASK_RESET  = 8'h20;
	localparam logic [7:0] ESC_BYTE    = 8'h7D;

	// Command kinds of a request.
	localparam logic [2:0] CMD_RESET     = 3'd0;
	localparam logic [2:0] CMD_BCAST     = 3'd1;
	localparam logic [2:0] CMD_SET_ADDR  = 3'd2;
	localparam logic [2:0] CMD_GET_MEAS  = 3'd3;
	localparam logic [2:0] CMD_GET_SP    = 3'd4;
	localparam logic [2:0] CMD_SET_SP    = 3'd5;

	// Command codes on the wire.
	localparam logic [7:0] CODE_RESET    = 8'hD3;
	localparam logic [7:0] CODE_SET_ADDR = 8'h90;
	localparam logic [7:0] CODE_GET_MEAS = 8'h08;
	localparam logic [7:0] CODE_SETPOINT = 8'h00;
	localparam logic [7:0] ADDR_BCAST    = 8'hFF;
	localparam logic [7:0] ADDR_NONE     = 8'h00;
	localparam logic [7:0] DATA_CHANNEL  = 8'h01;
	localparam logic [2:0] LEN_NONE      = 3'd0;
	localparam logic [2:0] LEN_ONE       = 3'd1;
	localparam logic [2:0] LEN_SET_SP    = 3'd5;

	// Byte source selected by a microcode step.
	localparam logic [2:0] SEL_DELIM = 3'd0;
	localparam logic [2:0] SEL_ADR   = 3'd1;
	localparam logic [2:0] SEL_CODE  = 3'd2;
	localparam logic [2:0] SEL_LEN   = 3'd3;
	localparam logic [2:0] SEL_DATA  = 3'd4;
	localparam logic [2:0] SEL_CHK   = 3'd5;

	// Sequencing kinds.
	localparam logic [1:0] JMP_NEXT     = 2'd0;
	localparam logic [1:0] JMP_IF_EMPTY = 2'd1;
	localparam logic [1:0] JMP_LOOP     = 2'd2;
	localparam logic [1:0] JMP_END      = 2'd3;

	// Program step addresses.
	localparam logic [2:0] STEP_SOF  = 3'd0;
	localparam logic [2:0] STEP_ADR  = 3'd1;
	localparam logic [2:0] STEP_CODE = 3'd2;
	localparam logic [2:0] STEP_LEN  = 3'd3;
	localparam logic [2:0] STEP_DATA = 3'd4;
	localparam logic [2:0] STEP_CHK  = 3'd5;
	localparam logic [2:0] STEP_EOF  = 3'd6;

	typedef struct packed {
		logic [2:0] sel;
		logic       stuff;
		logic       add;
		logic       last;
		logic [1:0] jmp;
		logic [2:0] target;
	} uword_t;

	// Sequencer to datapath.
	typedef struct packed {
		logic       busy;
		logic [2:0] sel;
		logic       stuff;
		logic       add;
		logic       last;
	} ctl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic adv;
		logic len_zero;
		logic data_more;
	} stat_t;

	function automatic uword_t rom_word(input logic [2:0] pc);
		uword_t w;
		case (pc)
			STEP_SOF:  w = '{SEL_DELIM, 1'b0, 1'b0, 1'b0, JMP_NEXT,     STEP_ADR};
			STEP_ADR:  w = '{SEL_ADR,   1'b1, 1'b1, 1'b0, JMP_NEXT,     STEP_CODE};
			STEP_CODE: w = '{SEL_CODE,  1'b1, 1'b1, 1'b0, JMP_NEXT,     STEP_LEN};
			STEP_LEN:  w = '{SEL_LEN,   1'b1, 1'b1, 1'b0, JMP_IF_EMPTY, STEP_CHK};
			STEP_DATA: w = '{SEL_DATA,  1'b1, 1'b1, 1'b0, JMP_LOOP,     STEP_DATA};
			STEP_CHK:  w = '{SEL_CHK,   1'b1, 1'b0, 1'b0, JMP_NEXT,     STEP_EOF};
			STEP_EOF:  w = '{SEL_DELIM, 1'b0, 1'b0, 1'b1, JMP_END,      STEP_SOF};
			default:   w = '{SEL_DELIM, 1'b0, 1'b0, 1'b1, JMP_END,      STEP_SOF};
		endcase
		return w;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return b == 8'h7E || b == 8'h7D || b == 8'h11 || b == 8'h13;
	endfunction

endpackage

@@ src/scfe_if.sv @@
interface scfe_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [7:0]  device_address;
	logic [31:0] setpoint_bits;

	modport source (output valid, output cmd, output device_address, output setpoint_bits,
		input ready);
	modport sink (input valid, input cmd, input device_address, input setpoint_bits,
		output ready);
endinterface

interface scfe_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;

	modport source (output valid, output out_byte, output is_last, input ready);
	modport sink (input valid, input out_byte, input is_last, output ready);
endinterface

@@ src/scfe_seq.sv @@
module scfe_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  scfe_pkg::stat_t stat,
	output scfe_pkg::ctl_t  ctl
);
	import scfe_pkg::*;

	logic [2:0] pc_q;
	logic       busy_q;
	uword_t     w;

	assign w = rom_word(pc_q);

	assign ctl.busy  = busy_q;
	assign ctl.sel   = w.sel;
	assign ctl.stuff = w.stuff;
	assign ctl.add   = w.add;
	assign ctl.last  = w.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= STEP_SOF;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= STEP_SOF;
			busy_q <= 1'b1;
		end else if (busy_q && stat.adv) begin
			case (w.jmp)
				JMP_NEXT:     pc_q <= pc_q + 3'd1;
				JMP_IF_EMPTY: pc_q <= stat.len_zero ? w.target : pc_q + 3'd1;
				JMP_LOOP:     pc_q <= stat.data_more ? w.target : pc_q + 3'd1;
				JMP_END: begin
					pc_q   <= w.target;
					busy_q <= 1'b0;
				end
				default:      pc_q <= STEP_SOF;
			endcase
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= STEP_EOF)
		else $error("step counter left the program");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("frame started while another is running");

endmodule

@@ src/scfe_dp.sv @@
module scfe_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [2:0]       cmd,
	input  logic [7:0]       device_address,
	input  logic [31:0]      setpoint_bits,
	input  logic [7:0]       delim,
	input  logic [7:0]       mask,
	input  scfe_pkg::ctl_t   ctl,
	output scfe_pkg::stat_t  stat,
	scfe_rsp_if.source       rsp
);
	import scfe_pkg::*;

	logic [7:0]      adr_q;
	logic [7:0]      code_q;
	logic [2:0]      len_q;
	logic [4:0][7:0] data_q;
	logic [2:0]      idx_q;
	logic [7:0]      sum_q;
	logic            esc_q;
	logic            ovalid_q;
	logic [7:0]      obyte_q;
	logic            olast_q;

	logic [7:0] fbyte;
	logic       esc_hit;
	logic       load;
	logic       adv;

	always_comb begin
		case (ctl.sel)
			SEL_DELIM: fbyte = delim;
			SEL_ADR:   fbyte = adr_q;
			SEL_CODE:  fbyte = code_q;
			SEL_LEN:   fbyte = {5'd0, len_q};
			SEL_DATA:  fbyte = data_q[idx_q];
			SEL_CHK:   fbyte = ~sum_q;
			default:   fbyte = delim;
		endcase
	end

	assign esc_hit = ctl.stuff && needs_escape(fbyte);
	assign load    = ctl.busy && (!ovalid_q || rsp.ready);
	// An escaped byte takes two loads; the step advances on the second.
	assign adv     = load && !(esc_hit && !esc_q);

	assign stat.adv       = adv;
	assign stat.len_zero  = len_q == LEN_NONE;
	assign stat.data_more = (idx_q + 3'd1) != len_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			adr_q      <= device_address;
			code_q     <= CODE_SETPOINT;
			len_q      <= LEN_ONE;
			data_q[0]  <= DATA_CHANNEL;
			data_q[1]  <= setpoint_bits[31:24];
			data_q[2]  <= setpoint_bits[23:16];
			data_q[3]  <= setpoint_bits[15:8];
			data_q[4]  <= setpoint_bits[7:0];
			case (cmd)
				CMD_RESET: begin
					code_q <= CODE_RESET;
					len_q  <= LEN_NONE;
				end
				CMD_BCAST: begin
					adr_q  <= ADDR_BCAST;
					code_q <= CODE_RESET;
					len_q  <= LEN_NONE;
				end
				CMD_SET_ADDR: begin
					adr_q     <= ADDR_NONE;
					code_q    <= CODE_SET_ADDR;
					data_q[0] <= device_address;
				end
				CMD_GET_MEAS: code_q <= CODE_GET_MEAS;
				CMD_GET_SP:   code_q <= CODE_SETPOINT;
				CMD_SET_SP:   len_q  <= LEN_SET_SP;
				default:      len_q  <= LEN_NONE;
			endcase
		end
		if (load) begin
			olast_q <= ctl.last;
			if (esc_hit && !esc_q) begin
				obyte_q <= ESC_BYTE;
			end else if (esc_q) begin
				obyte_q <= fbyte ^ mask;
			end else begin
				obyte_q <= fbyte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 3'd0;
			sum_q    <= 8'd0;
			esc_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= 3'd0;
				sum_q <= 8'd0;
			end else if (adv) begin
				if (ctl.sel == SEL_DATA) begin
					idx_q <= idx_q + 3'd1;
				end
				if (ctl.add) begin
					sum_q <= sum_q + fbyte;
				end
			end
			if (load) begin
				esc_q <= esc_hit && !esc_q;
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid    = ovalid_q;
	assign rsp.out_byte = obyte_q;
	assign rsp.is_last  = olast_q;

	a_esc_held: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> ovalid_q && rsp.out_byte == ESC_BYTE && ctl.busy)
		else $error("escape pending without an escape byte on the output");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd5)
		else $error("data index beyond the data bytes");

endmodule

@@ src/stuffed_command_frame_encoder.sv @@
// Channel  Dir  Payload                                    Accepted when
// req      in   cmd[2:0], device_address[7:0],             req.valid && req.ready
//               setpoint_bits[31:0]
// rsp      out  out_byte[7:0], is_last                     rsp.valid && rsp.ready
// cfg      in   cfg_we, cfg_index, cfg_wdata[7:0]          cfg_we
//
// A request is taken only while no frame is in progress; a frame of 6 to 17 bytes then
// leaves at one byte per cycle while rsp is not stalled, one microcode step per unstuffed
// byte and two output bytes for an escaped byte.
// An unknown command is taken and produces no bytes.
// Reset clears the sequencer, output valid and restores both registers.
// A stall on rsp holds the output byte and freezes the step counter.
module stuffed_command_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	scfe_req_if.sink   req,
	scfe_rsp_if.source rsp
);
	import scfe_pkg::*;

	logic [7:0] delim_q;
	logic [7:0] mask_q;
	ctl_t       ctl;
	stat_t      stat;
	logic       accept;
	logic       start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
			mask_q  <= MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELIM: delim_q <= cfg_wdata;
				CFG_MASK:  mask_q  <= cfg_wdata;
				default:   delim_q <= delim_q;
			endcase
		end
	end

	assign req.ready = !ctl.busy;
	assign accept    = req.valid && req.ready;
	assign start     = accept && req.cmd <= CMD_SET_SP;

	scfe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl)
	);

	scfe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cmd            (req.cmd),
		.device_address (req.device_address),
		.setpoint_bits  (req.setpoint_bits),
		.delim          (delim_q),
		.mask           (mask_q),
		.ctl            (ctl),
		.stat           (stat),
		.rsp            (rsp)
	);

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.is_last && !ctl.busy |=> !rsp.valid)
		else $error("byte emitted after the closing delimiter");

endmodule
